>>> rtl/pfn_pkg.sv
// Shared types and constants for the polygon fan and face normal block.
`default_nettype none
package pfn_pkg;
	localparam int POS_W = 24;
	localparam int COL_W = 16;
	localparam int NRM_W = 16;
	localparam int DIF_W = POS_W + 1;
	localparam int PRD_W = 2 * DIF_W;
	localparam int CRS_W = PRD_W + 1;
	localparam int MAG_BITS = 30;
	localparam int ONE_SHIFT = 14;
	localparam int NUM_W = MAG_BITS + ONE_SHIFT + 2;
	localparam int QUO_W = ONE_SHIFT + 1;
	localparam int SQ_W = 64;
	localparam int LEN_W = 32;
	localparam int IN_DATA_W = 136;
	localparam int OUT_DATA_W = 184;

	// vertices seen in the current polygon
	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [COL_W-1:0] r;
		logic [COL_W-1:0] g;
		logic [COL_W-1:0] b;
		logic [COL_W-1:0] a;
	} vtx_t;

	typedef struct packed {
		vtx_t v1;
		vtx_t v2;
		vtx_t v3;
	} tri_t;
endpackage
`default_nettype wire

>>> rtl/pfn_front.sv
// Front end: takes vertices, tracks first and previous vertex, issues fan triangles.
`default_nettype none
module pfn_front
	import pfn_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic in_start,
	input  vtx_t in_vtx,
	output logic tri_valid,
	input  wire logic tri_ready,
	output tri_t tri_data
);
	vtx_t first_q;
	vtx_t prev_q;
	logic [1:0] seen_q;
	logic accept;

	assign in_ready = tri_ready;
	assign accept = in_valid && in_ready;
	assign tri_valid = accept && !in_start && (seen_q == SEEN_TWO);
	assign tri_data = '{v1: first_q, v2: prev_q, v3: in_vtx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
		end else if (accept) begin
			if (in_start || seen_q == SEEN_NONE) begin
				seen_q <= SEEN_ONE;
			end else begin
				seen_q <= SEEN_TWO;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_start || seen_q == SEEN_NONE) begin
				first_q <= in_vtx;
			end
			prev_q <= in_vtx;
		end
	end
endmodule
`default_nettype wire

>>> rtl/pfn_fifo.sv
// Short triangle queue between front and back end.
`default_nettype none
module pfn_fifo
	import pfn_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic wr_ready,
	input  tri_t wr_data,
	output logic rd_valid,
	input  wire logic rd_ready,
	output tri_t rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	tri_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push;
	logic pop;

	assign wr_ready = (count_q != FULL);
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule
`default_nettype wire

>>> rtl/pfn_back.sv
// Back end: sequential face normal unit and an output register that emits the three vertices in turn.
`default_nettype none
module pfn_back
	import pfn_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tri_valid,
	output logic tri_ready,
	input  tri_t tri_data,
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic m_tlast
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL  = 9'b000000010,
		S_ABS  = 9'b000000100,
		S_NORM = 9'b000001000,
		S_SQ   = 9'b000010000,
		S_SQRT = 9'b000100000,
		S_DLD  = 9'b001000000,
		S_DIV  = 9'b010000000,
		S_EMIT = 9'b100000000
	} state_t;

	state_t state_q;
	tri_t tri_q;
	logic signed [DIF_W-1:0] d1_q [3];
	logic signed [DIF_W-1:0] d2_q [3];
	logic signed [PRD_W-1:0] prod_q;
	logic signed [PRD_W-1:0] acc_q;
	logic signed [CRS_W-1:0] c_q [3];
	logic [CRS_W-1:0] a_q [3];
	logic [2:0] sgn_q;
	logic [2:0] step_q;
	logic [SQ_W-1:0] x_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [LEN_W-1:0] len_q;
	logic [NUM_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [1:0] k_q;
	logic [3:0] i_q;
	logic signed [NRM_W-1:0] nrm_q [3];
	logic [1:0] emit_q;
	logic m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic m_last_q;

	logic signed [DIF_W-1:0] op_a;
	logic signed [DIF_W-1:0] op_b;
	logic signed [PRD_W-1:0] prod_c;
	logic [1:0] cidx;
	logic [CRS_W-1:0] ormag;
	logic [MAG_BITS-1:0] av;
	logic [2*MAG_BITS-1:0] sq_c;
	logic [SQ_W-1:0] trial;
	logic [NUM_W-1:0] shifted;
	logic [QUO_W-1:0] quo_n;
	logic take;
	logic load;
	vtx_t ev;

	assign tri_ready = (state_q == S_IDLE);
	assign take = tri_valid && tri_ready;
	assign load = (state_q == S_EMIT) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tlast = m_last_q;

	always_comb begin
		unique case (step_q)
			3'd0: begin op_a = d1_q[1]; op_b = d2_q[2]; end
			3'd1: begin op_a = d1_q[2]; op_b = d2_q[1]; end
			3'd2: begin op_a = d1_q[2]; op_b = d2_q[0]; end
			3'd3: begin op_a = d1_q[0]; op_b = d2_q[2]; end
			3'd4: begin op_a = d1_q[0]; op_b = d2_q[1]; end
			3'd5: begin op_a = d1_q[1]; op_b = d2_q[0]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign prod_c = op_a * op_b;
	assign cidx = step_q[2:1] - 2'd1;
	assign ormag = a_q[0] | a_q[1] | a_q[2];
	assign av = a_q[step_q[1:0]][MAG_BITS-1:0];
	assign sq_c = av * av;
	assign trial = res_q + bit_q;
	assign shifted = NUM_W'(len_q) << i_q;
	assign quo_n = (rem_q >= shifted) ? (quo_q | (QUO_W'(1) << i_q)) : quo_q;

	always_comb begin
		unique case (emit_q)
			2'd0: ev = tri_q.v1;
			2'd1: ev = tri_q.v2;
			default: ev = tri_q.v3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (take) state_q <= S_MUL;
				S_MUL:  if (step_q == 3'd6) state_q <= S_ABS;
				S_ABS:  state_q <= S_NORM;
				S_NORM: begin
					if (ormag == '0) begin
						state_q <= S_EMIT;
					end else if (ormag[CRS_W-1:MAG_BITS] == '0 && ormag[MAG_BITS-1]) begin
						state_q <= S_SQ;
					end
				end
				S_SQ:   if (step_q == 3'd2) state_q <= S_SQRT;
				S_SQRT: if (bit_q == SQ_W'(1)) state_q <= S_DLD;
				S_DLD:  state_q <= S_DIV;
				S_DIV: begin
					if (i_q == '0) begin
						state_q <= (k_q == 2'd2) ? S_EMIT : S_DLD;
					end
				end
				S_EMIT: if (load && emit_q == 2'd2) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					tri_q <= tri_data;
					d1_q[0] <= DIF_W'(tri_data.v2.x) - DIF_W'(tri_data.v1.x);
					d1_q[1] <= DIF_W'(tri_data.v2.y) - DIF_W'(tri_data.v1.y);
					d1_q[2] <= DIF_W'(tri_data.v2.z) - DIF_W'(tri_data.v1.z);
					d2_q[0] <= DIF_W'(tri_data.v3.x) - DIF_W'(tri_data.v1.x);
					d2_q[1] <= DIF_W'(tri_data.v3.y) - DIF_W'(tri_data.v1.y);
					d2_q[2] <= DIF_W'(tri_data.v3.z) - DIF_W'(tri_data.v1.z);
					step_q <= '0;
				end
			end
			S_MUL: begin
				prod_q <= prod_c;
				if (step_q[0]) begin
					acc_q <= prod_q;
				end else if (step_q != 3'd0) begin
					c_q[cidx] <= CRS_W'(acc_q) - CRS_W'(prod_q);
				end
				step_q <= step_q + 3'd1;
			end
			S_ABS: begin
				for (int i = 0; i < 3; i++) begin
					sgn_q[i] <= c_q[i][CRS_W-1];
					a_q[i] <= c_q[i][CRS_W-1] ? CRS_W'(-c_q[i]) : CRS_W'(c_q[i]);
					nrm_q[i] <= '0;
				end
				emit_q <= '0;
			end
			S_NORM: begin
				// bring the largest magnitude to exactly MAG_BITS bits, truncating
				if (ormag[CRS_W-1:MAG_BITS] != '0) begin
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
				end else if (!ormag[MAG_BITS-1]) begin
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
				end
				x_q <= '0;
				step_q <= '0;
			end
			S_SQ: begin
				x_q <= x_q + SQ_W'(sq_c);
				step_q <= step_q + 3'd1;
				res_q <= '0;
				bit_q <= SQ_W'(1) << 62;
			end
			S_SQRT: begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
					len_q <= LEN_W'((res_q >> 1) + bit_q);
				end else begin
					res_q <= res_q >> 1;
					len_q <= LEN_W'(res_q >> 1);
				end
				bit_q <= bit_q >> 2;
				k_q <= '0;
			end
			S_DLD: begin
				rem_q <= {2'b00, a_q[k_q][MAG_BITS-1:0], ONE_SHIFT'(0)}
					+ NUM_W'(len_q >> 1);
				quo_q <= '0;
				i_q <= 4'(ONE_SHIFT);
			end
			S_DIV: begin
				if (rem_q >= shifted) begin
					rem_q <= rem_q - shifted;
				end
				quo_q <= quo_n;
				if (i_q == '0) begin
					nrm_q[k_q] <= sgn_q[k_q] ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
					k_q <= k_q + 2'd1;
				end else begin
					i_q <= i_q - 4'd1;
				end
				emit_q <= '0;
			end
			S_EMIT: begin
				if (load) begin
					m_data_q <= {ev.a, ev.b, ev.g, ev.r, nrm_q[2], nrm_q[1], nrm_q[0],
						ev.z, ev.y, ev.x};
					m_last_q <= (emit_q == 2'd2);
					emit_q <= emit_q + 2'd1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/polygon_fan_flat_normal.sv
// Top level: polygon fan triangulation with a flat unit face normal per triangle.
//
// channel  dir  tdata fields (low bit up)                           side band
// s_*      in   pos_x, pos_y, pos_z, col_r, col_g, col_b, col_a      tuser: starts_polygon
// m_*      out  out_x, out_y, out_z, norm_x, norm_y, norm_z,         tlast: last_of_triangle
//               out_r, out_g, out_b, out_a
//
// Opening and second vertices are only stored. A triangle vertex waits in the queue;
// the back end takes it, then computes the normal in order: cross product, abs,
// normalize, square, square root and divide; a degenerate triangle goes from
// normalize straight to the emit step, which emits the three vertices in turn.
// Reset clears the vertex count, queue and state; a stalled m_tready holds
// the output register and backs up through the queue into s_tready.
`default_nettype none
module polygon_fan_flat_normal
	import pfn_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, col_r, col_g, col_b, col_a
	input  wire logic [0:0] s_tuser,            // starts_polygon
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,      // out_x, out_y, out_z, norm_x, norm_y, norm_z,
	                                            // out_r, out_g, out_b, out_a
	output logic m_tlast                        // last_of_triangle
);
	vtx_t in_vtx;
	tri_t f_tri;
	tri_t q_tri;
	logic f_valid;
	logic f_ready;
	logic q_valid;
	logic q_ready;

	assign in_vtx = '{x: s_tdata[23:0], y: s_tdata[47:24], z: s_tdata[71:48],
		r: s_tdata[87:72], g: s_tdata[103:88], b: s_tdata[119:104], a: s_tdata[135:120]};

	pfn_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_start(s_tuser[0]), .in_vtx(in_vtx),
		.tri_valid(f_valid), .tri_ready(f_ready), .tri_data(f_tri)
	);

	pfn_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tri),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tri)
	);

	pfn_back u_back (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(q_valid), .tri_ready(q_ready), .tri_data(q_tri),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);
endmodule
`default_nettype wire

>>> rtl/pfn_checker.sv
// Port-level checker for the polygon fan block, bound to the top level.
`default_nettype none
module pfn_checker
	import pfn_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [IN_DATA_W-1:0] s_tdata,
	input wire logic [0:0] s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic m_tlast
);
	logic [1:0] seen_q;
	logic [1:0] cnt_q;
	logic [7:0] pend_q;
	logic [3*NRM_W-1:0] nrm_q;
	logic in_acc;
	logic out_acc;
	logic new_tri;
	logic done_tri;

	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign new_tri = in_acc && !s_tuser[0] && seen_q == SEEN_TWO;
	assign done_tri = out_acc && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
			cnt_q <= '0;
			pend_q <= '0;
			nrm_q <= '0;
		end else begin
			if (in_acc) begin
				seen_q <= (s_tuser[0] || seen_q == SEEN_NONE) ? SEEN_ONE : SEEN_TWO;
			end
			if (out_acc) begin
				cnt_q <= m_tlast ? 2'd0 : cnt_q + 2'd1;
				nrm_q <= m_tdata[119:72];
			end
			if (new_tri && !done_tri) begin
				pend_q <= pend_q + 8'd1;
			end else if (done_tri && !new_tri) begin
				pend_q <= pend_q - 8'd1;
			end
		end
	end

	// hold the output while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// mark exactly every third vertex as last
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (cnt_q == 2'd2)))
		else $error("last flag out of step");

	// emit only vertices of triangles that were requested
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 8'd0)
		else $error("output without a pending triangle");

	// keep one normal across a triangle
	a_nrm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cnt_q != 2'd0 |-> m_tdata[119:72] == nrm_q)
		else $error("normal changed within a triangle");
endmodule

bind polygon_fan_flat_normal pfn_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
